[hw/rtl/vgmce_pkg.sv]
// Package for the VGM command stream encoder.
// Holds the beat payload structs, the request codes and the command byte constants.
// No dependencies.
package vgmce_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_WAIT  = 2'd1;
  localparam logic [1:0] REQ_LOOP  = 2'd2;
  localparam logic [1:0] REQ_END   = 2'd3;

  // Significant bits of wait_len (16 to 20)
  localparam int unsigned WaitBits = 20;

  // Command bytes
  localparam logic [7:0] CMD_WRITE      = 8'hB3;
  localparam logic [7:0] CMD_WAIT_LONG  = 8'h61;
  localparam logic [7:0] CMD_WAIT_NTSC  = 8'h62;
  localparam logic [7:0] CMD_WAIT_PAL   = 8'h63;
  localparam logic [7:0] CMD_END        = 8'h66;
  localparam logic [7:0] CMD_WAIT_SHORT = 8'h70;

  localparam logic [15:0] NtscFrameWait = 16'd735;
  localparam logic [15:0] PalFrameWait  = 16'd882;
  localparam logic [15:0] ShortWaitMax  = 16'd16;
  localparam logic [15:0] ChunkMax      = 16'hFFFF;

  localparam logic [31:0] PosStart   = 32'h0000_0100;
  localparam logic [31:0] LoopBias   = 32'h0000_001C;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_data;
    logic [19:0] wait_len;
  } vgmce_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_byte;
    logic [31:0] sample_count;
    logic        loop_valid;
    logic [31:0] loop_ofs;
    logic [31:0] loop_span;
    logic [31:0] stream_position;
  } vgmce_out_t;

endpackage

[hw/rtl/vgm_command_stream_encoder_core.sv]
// Top level of the VGM command stream encoder: a microcoded sequencer that turns
// register writes and sample waits into command byte beats.
// Depends on vgmce_pkg.

// Usage: each accepted request beat is expanded into zero or more output beats, one
// stream byte per beat, with last_byte set on the final beat of that request. A
// register write gives 0xB3, address, data; end gives 0x66; a loop mark gives no beat
// but records the stream position and sample total; a wait gives 0x62, 0x63 or
// 0x70+n-1 for the short forms, else 0x61 and a little-endian 16-bit count, split in
// 0xFFFF-sample chunks with the rest encoded again; a wait of zero gives nothing.
// Requests are taken one at a time, only in the idle step. A write runs the accept
// step, then the command, address and data steps; end and a loop mark run the accept
// and then their own step; a wait runs the accept, a classify step before each chunk,
// the command, low and high count steps per 0x61 chunk, or a short-form step for a
// short tail. The single output register takes one byte per cycle while out_stall_i
// does not hold it. A stalled output holds the emitting step. After reset the stream position is 0x100.
module vgm_command_stream_encoder_core import vgmce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  vgmce_in_t  in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output vgmce_out_t out_o
);

  localparam int unsigned StepBits = 4;
  typedef logic [StepBits-1:0] step_t;

  // Microprogram addresses
  localparam step_t ST_IDLE       = 4'd0;
  localparam step_t ST_WR_CMD     = 4'd1;
  localparam step_t ST_WR_ADDR    = 4'd2;
  localparam step_t ST_WR_DATA    = 4'd3;
  localparam step_t ST_WAIT_CLASS = 4'd4;
  localparam step_t ST_WAIT_SHORT = 4'd5;
  localparam step_t ST_WAIT_CMD   = 4'd6;
  localparam step_t ST_WAIT_LO    = 4'd7;
  localparam step_t ST_WAIT_HI    = 4'd8;
  localparam step_t ST_MARK       = 4'd9;
  localparam step_t ST_END        = 4'd10;

  typedef enum logic [2:0] {
    SRC_WRITE_CMD, SRC_ADDR, SRC_DATA, SRC_SHORT, SRC_LONG_CMD, SRC_LO, SRC_HI, SRC_END_CMD
  } src_e;

  typedef enum logic [1:0] {LAST_NEVER, LAST_ALWAYS, LAST_IF_DONE} last_e;

  typedef enum logic [1:0] {ACT_NONE, ACT_MARK, ACT_TAKE} act_e;

  typedef enum logic [2:0] {JMP_NEXT, JMP_IDLE, JMP_DISPATCH, JMP_CLASS, JMP_IF_MORE} jmp_e;

  // One control word per microprogram step
  typedef struct packed {
    logic  emit;
    src_e  src;
    last_e last;
    act_e  act;
    jmp_e  jmp;
    step_t target;
  } ctrl_t;

  // Control store. JMP_CLASS goes to target for a short wait, target+1 for a long one.
  function automatic ctrl_t rom_read(input step_t s);
    ctrl_t cw;
    cw = '{emit: 1'b0, src: SRC_WRITE_CMD, last: LAST_NEVER, act: ACT_NONE,
           jmp: JMP_IDLE, target: ST_IDLE};
    case (s)
      ST_IDLE: begin
        cw.jmp = JMP_DISPATCH;
      end
      ST_WR_CMD: begin
        cw.emit = 1'b1; cw.src = SRC_WRITE_CMD; cw.jmp = JMP_NEXT;
      end
      ST_WR_ADDR: begin
        cw.emit = 1'b1; cw.src = SRC_ADDR; cw.jmp = JMP_NEXT;
      end
      ST_WR_DATA: begin
        cw.emit = 1'b1; cw.src = SRC_DATA; cw.last = LAST_ALWAYS;
      end
      ST_WAIT_CLASS: begin
        cw.act = ACT_TAKE; cw.jmp = JMP_CLASS; cw.target = ST_WAIT_SHORT;
      end
      ST_WAIT_SHORT: begin
        cw.emit = 1'b1; cw.src = SRC_SHORT; cw.last = LAST_ALWAYS;
      end
      ST_WAIT_CMD: begin
        cw.emit = 1'b1; cw.src = SRC_LONG_CMD; cw.jmp = JMP_NEXT;
      end
      ST_WAIT_LO: begin
        cw.emit = 1'b1; cw.src = SRC_LO; cw.jmp = JMP_NEXT;
      end
      ST_WAIT_HI: begin
        cw.emit = 1'b1; cw.src = SRC_HI; cw.last = LAST_IF_DONE;
        cw.jmp = JMP_IF_MORE; cw.target = ST_WAIT_CLASS;
      end
      ST_MARK: begin
        cw.act = ACT_MARK;
      end
      ST_END: begin
        cw.emit = 1'b1; cw.src = SRC_END_CMD; cw.last = LAST_ALWAYS;
      end
      default: begin
        cw.jmp = JMP_IDLE;
      end
    endcase
    return cw;
  endfunction

  // Sequencer and stream state
  step_t       step_q, step_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] sample_total_q, sample_total_d;
  logic [31:0] byte_pos_q, byte_pos_d;
  logic        loop_marked_q, loop_marked_d;
  logic [31:0] loop_at_q, loop_at_d;
  logic [31:0] loop_mark_q, loop_mark_d;

  // Request payload and working values
  logic [7:0]          addr_q;
  logic [7:0]          data_q;
  logic [WaitBits-1:0] remaining_q, remaining_d;
  logic [15:0]         chunk_q, chunk_d;
  vgmce_out_t          out_q, out_d;

  ctrl_t       cw;
  logic        in_fire;
  logic        out_free;
  logic        emit_fire;
  logic        advance;
  logic        is_short;
  logic        is_big;
  logic [15:0] chunk_take;
  logic [7:0]  byte_sel;
  logic        last_sel;
  logic [31:0] pos_next;

  assign cw         = rom_read(step_q);
  assign in_stall_o = (step_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  // The output register takes a new beat when empty or being drained
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit_fire = cw.emit && out_free;
  assign advance   = cw.emit ? out_free : 1'b1;

  // Size the next wait chunk from what is left
  assign is_big     = (32'(remaining_q) > 32'(ChunkMax));
  assign chunk_take = is_big ? ChunkMax : remaining_q[15:0];
  assign is_short   = !is_big && ((remaining_q[15:0] == NtscFrameWait) ||
                                  (remaining_q[15:0] == PalFrameWait) ||
                                  (remaining_q[15:0] <= ShortWaitMax));

  // Byte select for the current step
  always_comb begin
    byte_sel = CMD_END;
    case (cw.src)
      SRC_WRITE_CMD: byte_sel = CMD_WRITE;
      SRC_ADDR:      byte_sel = addr_q;
      SRC_DATA:      byte_sel = data_q;
      SRC_SHORT: begin
        if (chunk_q == NtscFrameWait) begin
          byte_sel = CMD_WAIT_NTSC;
        end else if (chunk_q == PalFrameWait) begin
          byte_sel = CMD_WAIT_PAL;
        end else begin
          byte_sel = 8'(CMD_WAIT_SHORT + chunk_q[7:0] - 8'd1);
        end
      end
      SRC_LONG_CMD:  byte_sel = CMD_WAIT_LONG;
      SRC_LO:        byte_sel = chunk_q[7:0];
      SRC_HI:        byte_sel = chunk_q[15:8];
      SRC_END_CMD:   byte_sel = CMD_END;
      default:       byte_sel = CMD_END;
    endcase
  end

  always_comb begin
    case (cw.last)
      LAST_ALWAYS:  last_sel = 1'b1;
      LAST_IF_DONE: last_sel = (remaining_q == '0);
      default:      last_sel = 1'b0;
    endcase
  end

  assign pos_next = byte_pos_q + 32'd1;

  // Next state: step counter, stream counters and output register
  always_comb begin
    step_d         = step_q;
    out_valid_d    = out_valid_q;
    sample_total_d = sample_total_q;
    byte_pos_d     = byte_pos_q;
    loop_marked_d  = loop_marked_q;
    loop_at_d      = loop_at_q;
    loop_mark_d    = loop_mark_q;
    remaining_d    = remaining_q;
    chunk_d        = chunk_q;
    out_d          = out_q;

    // Drop the held beat once taken
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (in_fire) begin
      remaining_d = in_i.wait_len[WaitBits-1:0];
    end

    case (cw.act)
      ACT_MARK: begin
        loop_marked_d = 1'b1;
        loop_at_d     = byte_pos_q;
        loop_mark_d   = sample_total_q;
      end
      ACT_TAKE: begin
        if (remaining_q != '0) begin
          chunk_d        = chunk_take;
          sample_total_d = sample_total_q + 32'(chunk_take);
          remaining_d    = remaining_q - WaitBits'(chunk_take);
        end
      end
      default: ;
    endcase

    if (emit_fire) begin
      out_valid_d           = 1'b1;
      byte_pos_d            = pos_next;
      out_d.out_byte        = byte_sel;
      out_d.last_byte       = last_sel;
      out_d.sample_count    = sample_total_q;
      out_d.loop_valid      = loop_marked_q;
      out_d.loop_ofs        = loop_marked_q ? (loop_at_q - LoopBias) : '0;
      out_d.loop_span       = loop_marked_q ? (sample_total_q - loop_mark_q) : '0;
      out_d.stream_position = pos_next;
    end

    if (advance) begin
      case (cw.jmp)
        JMP_NEXT: step_d = step_q + step_t'(1);
        JMP_IDLE: step_d = ST_IDLE;
        JMP_DISPATCH: begin
          if (in_fire) begin
            case (in_i.req_type)
              REQ_WRITE: step_d = ST_WR_CMD;
              REQ_WAIT:  step_d = ST_WAIT_CLASS;
              REQ_LOOP:  step_d = ST_MARK;
              default:   step_d = ST_END;
            endcase
          end
        end
        JMP_CLASS: begin
          if (remaining_q == '0) begin
            step_d = ST_IDLE;
          end else if (is_short) begin
            step_d = cw.target;
          end else begin
            step_d = cw.target + step_t'(1);
          end
        end
        JMP_IF_MORE: step_d = (remaining_q != '0) ? cw.target : ST_IDLE;
        default:     step_d = ST_IDLE;
      endcase
    end
  end

  // Control and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q         <= ST_IDLE;
      out_valid_q    <= 1'b0;
      sample_total_q <= '0;
      byte_pos_q     <= PosStart;
      loop_marked_q  <= 1'b0;
      loop_at_q      <= '0;
      loop_mark_q    <= '0;
    end else begin
      step_q         <= step_d;
      out_valid_q    <= out_valid_d;
      sample_total_q <= sample_total_d;
      byte_pos_q     <= byte_pos_d;
      loop_marked_q  <= loop_marked_d;
      loop_at_q      <= loop_at_d;
      loop_mark_q    <= loop_mark_d;
    end
  end

  // Payload registers: hold the request fields, the wait working values and the beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      addr_q <= in_i.reg_addr;
      data_q <= in_i.reg_data;
    end
    remaining_q <= remaining_d;
    chunk_q     <= chunk_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Each emitted byte advances the stream position by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> (byte_pos_q == $past(byte_pos_q) + 32'd1))
    else $error("stream position did not advance by one on an emitted byte");

  // The count bytes of 0x61 always carry a chunk too long for the short forms
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_WAIT_LO) |-> (chunk_q > ShortWaitMax))
    else $error("long wait command carries a short chunk");

  // The sample total only moves in the wait classify step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != ST_WAIT_CLASS) |=> $stable(sample_total_q))
    else $error("sample total changed outside the classify step");

endmodule
